FILE: rtl/isl_pkg.sv
// Shared types and constants for the indexed sequential list.
package isl_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int POS_W = 5;
	localparam int WORD_W = 32;
	localparam int COUNT_W = 6;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_GET    = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] word;
	} cell_cmd_t;

endpackage

FILE: rtl/isl_cell.sv
// One storage cell of the list chain: holds a word and shifts with its neighbors.
module isl_cell #(
	parameter int INDEX = 0
) (
	input  logic                      clk,
	input  isl_pkg::cell_cmd_t        cmd,
	input  logic [isl_pkg::WORD_W-1:0] prev_data,
	input  logic [isl_pkg::WORD_W-1:0] next_data,
	output logic [isl_pkg::WORD_W-1:0] data,
	output logic [isl_pkg::WORD_W-1:0] rd_data
);
	import isl_pkg::*;

	localparam logic [8:0] IDX = 9'(INDEX);

	logic [WORD_W-1:0] data_q;
	logic [8:0]        pos_ext;
	logic              above;
	logic              here;

	assign pos_ext = {4'b0, cmd.pos};
	assign above   = IDX > pos_ext;
	assign here    = IDX == pos_ext;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			// open a gap at the position: later cells take from below
			if (above) begin
				data_q <= prev_data;
			end else if (here) begin
				data_q <= cmd.word;
			end
		end else if (cmd.rem) begin
			// close the gap: cells from the position on take from above
			if (above || here) begin
				data_q <= next_data;
			end
		end
	end

	assign data    = data_q;
	assign rd_data = here ? data_q : '0;

endmodule

FILE: rtl/indexed_sequential_list_core.sv
// Indexed sequential list: a bounded ordered list of signed 32-bit words held in a
// chain of CAPACITY cells. On an insert or remove, the cells from the addressed position
// on shift together in the same edge, so one request (insert, remove or get) is accepted
// per cycle while in_stall is low, and its result sits in an output register in the
// next cycle. in_stall rises only while that result waits for the
// downstream side. Out-of-range or overfilling requests leave the list unchanged
// and report a status code; count gives the low six bits of the entry count.
module indexed_sequential_list_core #(
	parameter int CAPACITY = isl_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  req_type,
	input  logic [isl_pkg::POS_W-1:0]   position,
	input  logic signed [isl_pkg::WORD_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic signed [isl_pkg::WORD_W-1:0] read_value,
	output logic [isl_pkg::COUNT_W-1:0] count
);
	import isl_pkg::*;

	localparam int FILL_W = $clog2(CAPACITY + 1);
	localparam int RD_N   = (CAPACITY < 32) ? CAPACITY : 32;
	localparam logic [8:0] CAP9 = 9'(CAPACITY);

	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_next;
	logic [8:0]        fill9;
	logic [8:0]        pos9;
	logic              accept;
	logic              ins_ok;
	logic              rem_ok;
	logic              get_ok;
	status_t           st;
	cell_cmd_t         cmd;

	logic [WORD_W-1:0] cell_data [CAPACITY];
	logic [WORD_W-1:0] rd_part [RD_N];
	logic [WORD_W-1:0] rd_word;

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [WORD_W-1:0] read_value_q;
	logic [COUNT_W-1:0] count_q;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign fill9    = 9'(fill_q);
	assign pos9     = {4'b0, position};

	always_comb begin
		ins_ok = 1'b0;
		rem_ok = 1'b0;
		get_ok = 1'b0;
		st     = ST_RANGE;
		case (req_t'(req_type))
			REQ_INSERT: begin
				if (fill9 >= CAP9) begin
					st = ST_FULL;
				end else if (pos9 <= fill9) begin
					ins_ok = 1'b1;
					st     = ST_OK;
				end
			end
			REQ_REMOVE: begin
				if (pos9 < fill9) begin
					rem_ok = 1'b1;
					st     = ST_OK;
				end
			end
			REQ_GET: begin
				if (pos9 < fill9) begin
					get_ok = 1'b1;
					st     = ST_OK;
				end
			end
			default: st = ST_RANGE;
		endcase
	end

	always_comb begin
		fill_next = fill_q;
		if (ins_ok) begin
			fill_next = fill_q + FILL_W'(1);
		end else if (rem_ok) begin
			fill_next = fill_q - FILL_W'(1);
		end
	end

	always_comb begin
		cmd.ins  = accept & ins_ok;
		cmd.rem  = accept & rem_ok;
		cmd.pos  = position;
		cmd.word = value;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_W-1:0] prev_w;
		logic [WORD_W-1:0] next_w;
		if (i == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_mid
			assign prev_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_inner
			assign next_w = cell_data[i+1];
		end
		if (i < RD_N) begin : g_rd
			isl_cell #(.INDEX(i)) u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.prev_data (prev_w),
				.next_data (next_w),
				.data      (cell_data[i]),
				.rd_data   (rd_part[i])
			);
		end else begin : g_nord
			// positions reach only the first cells; these are never read directly
			isl_cell #(.INDEX(i)) u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.prev_data (prev_w),
				.next_data (next_w),
				.data      (cell_data[i]),
				.rd_data   ()
			);
		end
	end

	// at most one cell matches the position, so an OR selects it
	always_comb begin
		rd_word = '0;
		for (int k = 0; k < RD_N; k++) begin
			rd_word = rd_word | rd_part[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= st;
			read_value_q <= get_ok ? rd_word : '0;
			count_q      <= COUNT_W'(9'(fill_next));
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign count      = count_q;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the indexed sequential list core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import isl_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam longint RUN_LIMIT_NS = 3_000_000;

	typedef struct {
		req_t                     op;
		logic [POS_W-1:0]         pos;
		logic signed [WORD_W-1:0] word;
		int                       gap;
		bit                       drain;
	} list_req_t;

	typedef struct {
		status_t                  st;
		logic signed [WORD_W-1:0] rd;
		logic [COUNT_W-1:0]       cnt;
	} list_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               req_type = REQ_INSERT;
	logic [POS_W-1:0]         position = '0;
	logic signed [WORD_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [1:0]               status;
	logic signed [WORD_W-1:0] read_value;
	logic [COUNT_W-1:0]       count;

	list_req_t    pending_reqs[$];
	list_result_t expected_results[$];

	// Shadow copy of the list contents and length.
	logic signed [WORD_W-1:0] list_words[CAP];
	int                       list_len = 0;

	// Length tracker used while building the stimulus.
	int  plan_len = 0;
	bit  quiet_mode = 1'b0;
	bit  drain_next = 1'b0;

	list_req_t    cur;
	list_result_t want;
	bit           took;
	int           gap_left = 0;
	int           hold_left = 0;
	bit           rx_quiet = 1'b0;
	bit           long_hold = 1'b0;
	int           reqs_sent = 0;
	int           results_seen = 0;
	int           failures = 0;

	indexed_sequential_list_core #(
		.CAPACITY(CAP)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.position  (position),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.read_value(read_value),
		.count     (count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic list_result_t apply_request(req_t op, logic [POS_W-1:0] pos,
			logic signed [WORD_W-1:0] word);
		list_result_t r;
		int k;
		r.st = ST_RANGE;
		r.rd = '0;
		case (op)
			REQ_INSERT: begin
				if (list_len >= CAP) begin
					r.st = ST_FULL;
				end else if (int'(pos) <= list_len) begin
					for (k = list_len; k > int'(pos); k--)
						list_words[k] = list_words[k-1];
					list_words[pos] = word;
					list_len++;
					r.st = ST_OK;
				end
			end
			REQ_REMOVE: begin
				if (int'(pos) < list_len) begin
					for (k = int'(pos); k + 1 < list_len; k++)
						list_words[k] = list_words[k+1];
					list_words[list_len-1] = '0;
					list_len--;
					r.st = ST_OK;
				end
			end
			REQ_GET: begin
				if (int'(pos) < list_len) begin
					r.rd = list_words[pos];
					r.st = ST_OK;
				end
			end
			default: ;
		endcase
		r.cnt = COUNT_W'(list_len);
		return r;
	endfunction

	function automatic logic signed [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	function automatic void add_req(req_t op, int pos, logic signed [WORD_W-1:0] word);
		list_req_t it;
		it.op = op;
		it.pos = POS_W'(pos);
		it.word = word;
		it.gap = quiet_mode ? 0 : $urandom_range(0, 12);
		it.drain = drain_next;
		drain_next = 1'b0;
		pending_reqs.push_back(it);
		case (op)
			REQ_INSERT: if (plan_len < CAP && pos <= plan_len) plan_len++;
			REQ_REMOVE: if (pos < plan_len) plan_len--;
			default: ;
		endcase
	endfunction

	task automatic plan_stimulus();
		int seg;
		int kind;
		int r;
		req_t op;
		int pos;
		// empty list: every access is out of range
		add_req(REQ_GET, 0, 0);
		add_req(REQ_REMOVE, 0, 0);
		add_req(REQ_NONE, 0, 0);
		add_req(REQ_INSERT, 1, 5);
		// front, append, front and middle inserts with extreme words
		add_req(REQ_INSERT, 0, 32'sh7fff_ffff);
		add_req(REQ_INSERT, 1, 32'sh8000_0000);
		add_req(REQ_INSERT, 0, 0);
		add_req(REQ_INSERT, 1, -1);
		for (int i = 0; i <= 4; i++)
			add_req(REQ_GET, i, 0);
		add_req(REQ_GET, 31, 0);
		add_req(REQ_INSERT, 5, 32'sh1234_5678);
		add_req(REQ_REMOVE, 1, 0);
		add_req(REQ_REMOVE, 2, 0);
		add_req(REQ_NONE, 31, -1);
		add_req(REQ_GET, 1, 0);
		add_req(REQ_REMOVE, 0, 0);
		add_req(REQ_REMOVE, 0, 0);
		add_req(REQ_REMOVE, 0, 0);

		seg = 0;
		while (pending_reqs.size() < 630) begin
			kind = (seg == 0) ? 0 : $urandom_range(0, 3);
			quiet_mode = ($urandom_range(0, 3) == 0);
			drain_next = (seg == 1) || ($urandom_range(0, 3) == 0);
			case (kind)
				0: begin
					// fill to capacity, then push against the full list
					while (plan_len < CAP)
						add_req(REQ_INSERT, $urandom_range(0, plan_len), rand_word());
					add_req(REQ_INSERT, $urandom_range(0, 31), rand_word());
					add_req(REQ_GET, 31, rand_word());
					add_req(REQ_INSERT, $urandom_range(0, 31), rand_word());
				end
				1: begin
					while (plan_len > 0)
						add_req(REQ_REMOVE, $urandom_range(0, plan_len - 1), rand_word());
					add_req(REQ_GET, $urandom_range(0, 31), rand_word());
				end
				default: begin
					repeat (30) begin
						r = $urandom_range(0, 99);
						op = (r < 38) ? REQ_INSERT : (r < 68) ? REQ_REMOVE :
							(r < 95) ? REQ_GET : REQ_NONE;
						if ($urandom_range(0, 9) == 0)
							pos = $urandom_range(0, 31);
						else if (op == REQ_INSERT)
							pos = $urandom_range(0, (plan_len < 31) ? plan_len : 31);
						else
							pos = (plan_len > 0) ? $urandom_range(0, plan_len - 1) : 0;
						add_req(op, pos, rand_word());
					end
				end
			endcase
			seg++;
		end
	endtask

	// Driver: hold a stalled transfer, else idle out the gap, else offer the next item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			took = in_valid && !in_stall;
			if (took) begin
				expected_results.push_back(apply_request(cur.op, cur.pos, cur.word));
				gap_left = cur.gap;
				reqs_sent++;
			end
			if (!(in_valid && !took)) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (pending_reqs.size() != 0 &&
						!(pending_reqs[0].drain && expected_results.size() != 0)) begin
					cur = pending_reqs.pop_front();
					in_valid <= 1'b1;
					req_type <= cur.op;
					position <= cur.pos;
					value <= cur.word;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer and pace the stall line.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d read_value %0d count %0d",
						status, read_value, count);
					failures++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						failures++;
					end
					if (read_value !== want.rd) begin
						$error("read_value: expected %0d, got %0d", want.rd, read_value);
						failures++;
					end
					if (count !== want.cnt) begin
						$error("count: expected %0d, got %0d", want.cnt, count);
						failures++;
					end
				end
				results_seen++;
				if (results_seen % 40 == 0)
					rx_quiet = ($urandom_range(0, 2) == 0);
				hold_left = rx_quiet ? 0 : $urandom_range(0, 12);
			end else if (hold_left > 0) begin
				hold_left--;
			end
			out_stall <= long_hold || (hold_left > 0);
		end
	end

	// Long receiver hold-off while the sender keeps offering.
	initial begin
		while (reqs_sent < 250)
			@(posedge clk);
		long_hold <= 1'b1;
		repeat (200) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		plan_stimulus();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
rtl/isl_pkg.sv
rtl/isl_cell.sv
rtl/indexed_sequential_list_core.sv
tb/sv/testbench.sv
